// File: sv/hsgi_pkg.sv
// Shared types, constants and set tables for the Hangul glyph index core.
// No dependencies; every other file imports this package.
package hsgi_pkg;

  localparam int unsigned IdxW   = 9;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [15:0] HANGUL_BASE = 16'hAC00;
  localparam logic [15:0] HANGUL_LAST = 16'hD7A3;

  // layer codes on the result channel
  localparam logic [1:0] LAYER_CHO  = 2'd0;
  localparam logic [1:0] LAYER_JUNG = 2'd1;
  localparam logic [1:0] LAYER_JONG = 2'd2;

  // reciprocals: x/7 for x < 2793 and t/21 for t < 399 are exact with these
  localparam logic [13:0] RECIP_7  = 14'd9363;
  localparam logic [9:0]  RECIP_21 = 10'd781;

  localparam logic [8:0] JUNG_BASE = 9'd160;
  localparam logic [8:0] JONG_BASE = 9'd248;

  // initial set without final, indexed by medial 1..21
  localparam logic [2:0] SET_CHO_OPEN [22] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3,
    3'd3, 3'd3, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0
  };
  // initial set with final, indexed by medial 1..21
  localparam logic [2:0] SET_CHO_CLOSED [22] = '{
    3'd0, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd7,
    3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd7, 3'd5
  };
  // final set, indexed by medial 1..21
  localparam logic [1:0] SET_JONG [22] = '{
    2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0,
    2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1
  };

  // one classified syllable, handed from front to back
  typedef struct packed {
    logic [IdxW-1:0] idx_cho;
    logic [IdxW-1:0] idx_jung;
    logic [IdxW-1:0] idx_jong;
    logic            has_final;
    logic            bad;
  } hsgi_rec_t;

endpackage

// File: sv/hangul_syllable_glyph_index_core.sv
// Top level of the Hangul syllable to 8x4x4 font record index core.
// Depends on hsgi_pkg, hsgi_front, hsgi_queue and hsgi_back.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   in_      | input     | in_valid / in_stall  | lead, second, third UTF-8 byte
//   out_     | output    | out_valid / out_stall| glyph_index, layer, last, bad
//
// Each syllable beat gives two or three record beats (one for a bad code).
// The back part sends one record a cycle from its output register while
// out_stall is low and the queue is not empty; the first record of a
// syllable passes the stage 1 register, the queue and the output register
// before it is shown. Two front stages (offset / 28, then / 21 and set
// tables) feed a four-entry queue that decouples the sides.
// Reset (rst_n low, synchronous) empties the pipeline, queue and output
// register; no clearing pass. out_stall holds the record in place; in_stall
// rises only once the queue is full and the front stage is occupied.
module hangul_syllable_glyph_index_core import hsgi_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_lead_byte,
  input  logic [7:0]      in_second_byte,
  input  logic [7:0]      in_third_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [IdxW-1:0] out_glyph_index,
  output logic [1:0]      out_layer,
  output logic            out_last,
  output logic            out_bad_code
);

  hsgi_rec_t push_rec;
  hsgi_rec_t head_rec;
  logic      push;
  logic      pop;
  logic      q_empty;
  logic      q_full;

  // classify: byte beats in, one record per syllable into the queue
  hsgi_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_lead_byte   (in_lead_byte),
    .in_second_byte (in_second_byte),
    .in_third_byte  (in_third_byte),
    .push           (push),
    .push_rec       (push_rec),
    .q_full         (q_full)
  );

  // hold classified syllables so either side may stall on its own
  hsgi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (q_empty),
    .full     (q_full)
  );

  // sequence initial, medial and final record beats
  hsgi_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_rec        (head_rec),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_glyph_index (out_glyph_index),
    .out_layer       (out_layer),
    .out_last        (out_last),
    .out_bad_code    (out_bad_code)
  );

endmodule

// File: sv/hsgi_queue.sv
// Short FIFO of classified syllables between front and back.
// Depends on hsgi_pkg (record type, depth).
module hsgi_queue import hsgi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  hsgi_rec_t push_rec,
  input  logic      pop,
  output hsgi_rec_t head_rec,
  output logic      empty,
  output logic      full
);

  hsgi_rec_t        mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPtrW:0]   count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (QPtrW+1)'(QDepth));
  assign head_rec = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// File: sv/hsgi_front.sv
// Front part: accepts syllable beats, splits the offset into jamo and picks
// font sets over two stages. Depends on hsgi_pkg.
module hsgi_front import hsgi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [7:0] in_lead_byte,
  input  logic [7:0] in_second_byte,
  input  logic [7:0] in_third_byte,
  output logic      push,
  output hsgi_rec_t push_rec,
  input  logic      q_full
);

  // stage 1: code point, offset, offset / 28
  logic [15:0] code;
  logic        bad;
  logic [13:0] off;
  logic [25:0] div7_prod;
  logic [8:0]  t;

  logic        s1_v_r, s1_v_nxt;
  logic [13:0] s1_off_r;
  logic [8:0]  s1_t_r;
  logic        s1_bad_r;

  // stage 2: jamo split and set tables
  logic [18:0] div21_prod;
  logic [4:0]  cho0;
  logic [13:0] t28;
  logic [4:0]  jong;
  logic [8:0]  cho21;
  logic [4:0]  jung;
  logic [4:0]  cho;
  logic        has_final;
  logic        giyeok_like;
  logic [2:0]  cho_set;
  logic [1:0]  jung_set;
  logic [1:0]  jong_set;

  logic        s2_take;
  logic        s1_take;

  assign code = {in_lead_byte[3:0], in_second_byte[5:0], in_third_byte[5:0]};
  assign bad  = (code < HANGUL_BASE) || (code > HANGUL_LAST);
  assign off  = 14'(code - HANGUL_BASE);
  // off/28 = (off>>2)/7
  assign div7_prod = 26'(off[13:2]) * 26'(RECIP_7);
  assign t         = div7_prod[24:16];

  assign s2_take  = !s1_v_r || !q_full;
  assign s1_take  = s2_take;
  assign in_stall = !s1_take;
  assign s1_v_nxt = s1_take ? in_valid : s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_off_r <= off;
      s1_t_r   <= t;
      s1_bad_r <= bad;
    end
  end

  always_comb begin
    div21_prod  = 19'(s1_t_r) * 19'(RECIP_21);
    cho0        = div21_prod[18:14];
    t28         = 14'(s1_t_r) * 14'd28;
    jong        = 5'(s1_off_r - t28);
    cho21       = 9'(cho0) * 9'd21;
    jung        = 5'(s1_t_r - cho21) + 5'd1;
    cho         = cho0 + 5'd1;
    has_final   = (jong != 5'd0);
    giyeok_like = (cho0 == 5'd0) || (cho0 == 5'd15);
    cho_set     = has_final ? SET_CHO_CLOSED[jung] : SET_CHO_OPEN[jung];
    jung_set    = {has_final, !giyeok_like};
    jong_set    = has_final ? SET_JONG[jung] : 2'd0;

    push_rec.idx_cho  = 9'(cho_set) * 9'd20 + 9'(cho);
    push_rec.idx_jung = JUNG_BASE + 9'(jung_set) * 9'd22 + 9'(jung);
    push_rec.idx_jong = JONG_BASE + 9'(jong_set) * 9'd28 + 9'(jong);
    push_rec.has_final = has_final;
    push_rec.bad       = s1_bad_r;
    if (s1_bad_r) begin
      push_rec.idx_cho = '0;
    end
  end

  assign push = s1_v_r && !q_full;

endmodule

// File: sv/hsgi_back.sv
// Back part: pops classified syllables and sends one record beat a cycle
// unless stalled or empty, through an output register. Depends on hsgi_pkg.
module hsgi_back import hsgi_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  hsgi_rec_t       head_rec,
  input  logic            q_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [IdxW-1:0] out_glyph_index,
  output logic [1:0]      out_layer,
  output logic            out_last,
  output logic            out_bad_code
);

  typedef enum logic [2:0] {
    PH_CHO  = 3'b001,
    PH_JUNG = 3'b010,
    PH_JONG = 3'b100
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [IdxW-1:0] idx_r;
  logic [1:0]      layer_r;
  logic            last_r;
  logic            bad_r;

  logic            load;
  logic [IdxW-1:0] sel_idx;
  logic [1:0]      sel_layer;
  logic            sel_last;
  phase_t          sel_next;

  assign load = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    case (phase_r)
      PH_CHO: begin
        sel_idx   = head_rec.idx_cho;
        sel_layer = LAYER_CHO;
        sel_last  = head_rec.bad;
        sel_next  = PH_JUNG;
      end
      PH_JUNG: begin
        sel_idx   = head_rec.idx_jung;
        sel_layer = LAYER_JUNG;
        sel_last  = !head_rec.has_final;
        sel_next  = PH_JONG;
      end
      default: begin
        sel_idx   = head_rec.idx_jong;
        sel_layer = LAYER_JONG;
        sel_last  = 1'b1;
        sel_next  = PH_CHO;
      end
    endcase
  end

  assign pop = load && sel_last;

  always_comb begin
    phase_nxt = phase_r;
    if (load) begin
      phase_nxt = sel_last ? PH_CHO : sel_next;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CHO;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx_r   <= sel_idx;
      layer_r <= sel_layer;
      last_r  <= sel_last;
      bad_r   <= head_rec.bad;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_glyph_index = idx_r;
  assign out_layer       = layer_r;
  assign out_last        = last_r;
  assign out_bad_code    = bad_r;

endmodule

// File: sv/hsgi_checker.sv
// Port-level checks on the glyph index core, bound to the top level.
// Depends on hsgi_pkg.
module hsgi_checker import hsgi_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [IdxW-1:0] out_glyph_index,
  input logic [1:0]      out_layer,
  input logic            out_last,
  input logic            out_bad_code
);

  // a stalled record beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_glyph_index) &&
    $stable(out_layer) && $stable(out_last) && $stable(out_bad_code))
    else $error("stalled result beat changed");

  // a bad code is a single, zeroed initial record
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_code |->
    out_last && out_layer == LAYER_CHO && out_glyph_index == '0)
    else $error("bad code record malformed");

  // final layer always closes the syllable and lies in the final range
  a_jong_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_layer == LAYER_JONG |-> out_last && out_glyph_index >= JONG_BASE)
    else $error("final record not last or out of range");

  // after a non-last record taken, the next record is never an initial
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last ##1 out_valid |-> out_layer != LAYER_CHO)
    else $error("syllable cut short");

  // input stall only rises behind a beat that was offered the cycle before
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stalled with nothing taken");

endmodule

bind hangul_syllable_glyph_index_core hsgi_checker u_hsgi_checker (.*);
